@@ src/wbps_pkg.sv @@
`timescale 1ns / 1ps

package wbps_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int POS_W       = $clog2(PATTERN_MAX);
    localparam int LEN_W       = 5;
    localparam int SEEN_W      = 25;
    localparam int HITS_W      = 16;
    localparam int SCAN_W      = 24;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};
    localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_WILDCARD_MASK  = 3'd2,
        REG_PATTERN_LENGTH = 3'd3,
        REG_SEARCH_UP      = 3'd4,
        REG_SCAN_COUNT     = 3'd5,
        REG_WANTED_OCC     = 3'd6
    } cfg_reg_t;

    typedef logic [PATTERN_MAX-1:0][7:0] window_t;

    typedef struct packed {
        logic [63:0]             pattern_low;
        logic [63:0]             pattern_high;
        logic [PATTERN_MAX-1:0]  wildcard_mask;
        logic [LEN_W-1:0]        pattern_length;
        logic                    search_up;
        logic [SCAN_W-1:0]       scan_count;
        logic [HITS_W-1:0]       wanted_occurrence;
    } cfg_t;

endpackage

@@ src/wildcard_byte_pattern_scanner.sv @@
`timescale 1ns / 1ps

// Wildcard byte pattern scanner.
// Feed memory bytes in scan order on the s_axis side, one per beat; set
// tuser on the first beat of a scan to clear the window and the counters.
// Each accepted beat yields exactly one result beat on the m_axis side:
// window match and found flags in tuser, the window distance in tdata and
// scan done in tlast. Once a scan is done, further bytes give done-only
// results until the next first-byte beat.
// Configuration is written through cfg_wr_en/cfg_addr/cfg_wdata while the
// stream is idle; the register index follows cfg_reg_t in wbps_pkg.
// Pipeline: each byte passes through the input register, then the result
// register, before its result beat is presented. Throughput: one byte per
// cycle while the receiver takes the results; all sixteen pattern positions
// are compared in parallel in one pass.
// Reset clears the window, counters, the pipeline valids and the registers
// to their defaults (length 1, occurrence 1). When the receiver stalls, the
// result register holds and the input register fills; s_axis_tready drops
// only when both are occupied and m_axis_tready is low.
module wildcard_byte_pattern_scanner
    import wbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] mem_byte
    input  logic                  s_axis_tuser,   // [0] first_byte
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [31:0]           m_axis_tdata,   // [24:0] match_distance, rest zero
    output logic [1:0]            m_axis_tuser,   // [0] window_match, [1] found
    output logic                  m_axis_tlast    // scan_done
);

    cfg_t             cfg;
    logic [LEN_W-1:0] len_eff;

    wbps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .len_eff   (len_eff)
    );

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;

    // Scan state
    window_t           win_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic [HITS_W-1:0] hits_reg;
    logic              finished_reg;

    // Result register
    logic              out_valid_reg;
    logic              out_match_reg;
    logic              out_found_reg;
    logic [SEEN_W-1:0] out_dist_reg;
    logic              out_done_reg;

    logic out_free;
    logic advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    // State as seen by the byte in the input register: a first byte starts clean
    window_t           eff_win;
    logic [SEEN_W-1:0] eff_seen;
    logic [HITS_W-1:0] eff_hits;
    logic              eff_fin;

    assign eff_win  = in_first_reg ? '0 : win_reg;
    assign eff_seen = in_first_reg ? '0 : seen_reg;
    assign eff_hits = in_first_reg ? '0 : hits_reg;
    assign eff_fin  = in_first_reg ? 1'b0 : finished_reg;

    window_t           win_next;
    logic [SEEN_W-1:0] seen_next;
    logic [HITS_W-1:0] hits_next;
    logic              match;
    logic              tested;
    logic              hit;
    logic              done;
    logic [SEEN_W:0]   limit;
    logic [SEEN_W:0]   win_idx;
    logic [SEEN_W+1:0] done_lhs;
    logic [SEEN_W+1:0] done_rhs;

    // Shift the new byte in as the newest slot
    assign win_next  = {eff_win[PATTERN_MAX-2:0], in_byte_reg};
    assign seen_next = (eff_seen == SEEN_MAX) ? eff_seen : eff_seen + SEEN_W'(1);

    wbps_match u_match (
        .window  (win_next),
        .cfg     (cfg),
        .len_eff (len_eff),
        .match   (match)
    );

    // Last tested window is scan_count + len - 1; window index is seen - len + 1
    assign limit    = (SEEN_W+1)'(cfg.scan_count) + (SEEN_W+1)'(len_eff) - (SEEN_W+1)'(1);
    assign win_idx  = (SEEN_W+1)'(seen_next) - (SEEN_W+1)'(len_eff) + (SEEN_W+1)'(1);
    assign tested   = (seen_next >= SEEN_W'(len_eff)) && (win_idx <= limit);

    assign hits_next = (tested && match && (eff_hits != HITS_MAX))
                       ? eff_hits + HITS_W'(1) : eff_hits;
    assign hit       = tested && match && (cfg.wanted_occurrence != '0)
                       && (hits_next == cfg.wanted_occurrence);

    // Stop once the stream has passed the end of the last window
    assign done_lhs = (SEEN_W+2)'(seen_next) + (SEEN_W+2)'(1);
    assign done_rhs = (SEEN_W+2)'(limit) + (SEEN_W+2)'(len_eff);
    assign done     = hit || (done_lhs >= done_rhs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            win_reg       <= '0;
            seen_reg      <= '0;
            hits_reg      <= '0;
            finished_reg  <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            // Hold state for bytes that arrive after the scan finished
            if (advance && !eff_fin)
            begin
                win_reg      <= win_next;
                seen_reg     <= seen_next;
                hits_reg     <= hits_next;
                finished_reg <= done;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_first_reg <= s_axis_tuser;
        end
        if (advance)
        begin
            if (eff_fin)
            begin
                out_match_reg <= 1'b0;
                out_found_reg <= 1'b0;
                out_dist_reg  <= '0;
                out_done_reg  <= 1'b1;
            end
            else
            begin
                out_match_reg <= tested && match;
                out_found_reg <= hit;
                out_dist_reg  <= tested ? win_idx[SEEN_W-1:0] : '0;
                out_done_reg  <= done;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(32 - SEEN_W)'(0), out_dist_reg};
    assign m_axis_tuser  = {out_found_reg, out_match_reg};
    assign m_axis_tlast  = out_done_reg;

endmodule

@@ src/wbps_cfg.sv @@
`timescale 1ns / 1ps

module wbps_cfg
    import wbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg,
    output logic [LEN_W-1:0]      len_eff
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg                   <= '0;
            cfg_reg.pattern_length    <= LEN_W'(1);
            cfg_reg.wanted_occurrence <= HITS_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_PATTERN_LOW:    cfg_reg.pattern_low       <= cfg_wdata;
                REG_PATTERN_HIGH:   cfg_reg.pattern_high      <= cfg_wdata;
                REG_WILDCARD_MASK:  cfg_reg.wildcard_mask     <= cfg_wdata[PATTERN_MAX-1:0];
                REG_PATTERN_LENGTH: cfg_reg.pattern_length    <= cfg_wdata[LEN_W-1:0];
                REG_SEARCH_UP:      cfg_reg.search_up         <= cfg_wdata[0];
                REG_SCAN_COUNT:     cfg_reg.scan_count        <= cfg_wdata[SCAN_W-1:0];
                REG_WANTED_OCC:     cfg_reg.wanted_occurrence <= cfg_wdata[HITS_W-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

    // Clamp length: zero acts as one, anything above the maximum as the maximum
    always_comb
    begin
        priority if (cfg_reg.pattern_length == '0)
            len_eff = LEN_W'(1);
        else if (cfg_reg.pattern_length > LEN_W'(PATTERN_MAX))
            len_eff = LEN_W'(PATTERN_MAX);
        else
            len_eff = cfg_reg.pattern_length;
    end

endmodule

@@ src/wbps_match.sv @@
`timescale 1ns / 1ps

module wbps_match
    import wbps_pkg::*;
(
    input  window_t          window,
    input  cfg_t             cfg,
    input  logic [LEN_W-1:0] len_eff,
    output logic             match
);

    window_t                            pat;
    logic [PATTERN_MAX-1:0][POS_W-1:0]  pos;
    logic [PATTERN_MAX-1:0]             ok;
    logic [POS_W-1:0]                   len_m1;

    assign pat    = {cfg.pattern_high, cfg.pattern_low};
    assign len_m1 = POS_W'(len_eff - LEN_W'(1));

    // Slot k holds the k-th newest byte; pick the pattern byte it faces
    always_comb
    begin
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            pos[k] = cfg.search_up ? POS_W'(k) : POS_W'(len_m1 - POS_W'(k));
            ok[k]  = (LEN_W'(k) >= len_eff) || cfg.wildcard_mask[pos[k]]
                     || (window[k] == pat[pos[k]]);
        end
    end

    assign match = &ok;

endmodule
